// ===== rtl/core/sdspi_pkg.sv =====
// Package: shared types and constants for the SPI-mode SD command engine
package sdspi_pkg;

   localparam logic [1:0] FUNC_CMD   = 2'd0;
   localparam logic [1:0] FUNC_BYTE  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_WRITE = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOT_RDY  = 3'd1;
   localparam logic [2:0] ST_RESP_TO  = 3'd2;
   localparam logic [2:0] ST_PREFIX   = 3'd3;
   localparam logic [2:0] ST_NO_TOKEN = 3'd4;
   localparam logic [2:0] ST_BAD_TOK  = 3'd5;
   localparam logic [2:0] ST_WR_REJ   = 3'd6;

   localparam logic [2:0] REG_BLOCK_BYTES = 3'd0;
   localparam logic [2:0] REG_RESP_TO     = 3'd1;
   localparam logic [2:0] REG_READY_TRIES = 3'd2;
   localparam logic [2:0] REG_TOKEN_TRIES = 3'd3;
   localparam logic [2:0] REG_MAX_RESP    = 3'd4;

   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] TOKEN_READ = 8'hFE;
   localparam logic [6:0] CRC7_POLY  = 7'h09;
   localparam logic [5:0] APP_CMD_IX = 6'd55;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  cmd_index;
      logic        app_cmd;
      logic [31:0] cmd_arg;
      logic [7:0]  write_token;
      logic [7:0]  miso_byte;
      logic [7:0]  tx_data;
   } req_type;

   typedef struct packed {
      logic        exchange;
      logic [7:0]  mosi_byte;
      logic        select;
      logic        need_tx_data;
      logic        resp_valid;
      logic [7:0]  resp_byte;
      logic [11:0] resp_index;
      logic        done_res;
      logic [2:0]  status;
   } rsp_type;

   function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
      logic [6:0] c;
      logic fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = b[i] ^ c[6];
         c = {c[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'd0);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/sdspi_stream_if.sv =====
// Interface: valid/ready channel carrying one payload beat
interface sdspi_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sd_spi_command_engine_top.sv =====
// Top level: SPI-mode SD host byte sequencer
//
//  channel | dir | payload
//  req     | in  | func, cmd_index, app_cmd, cmd_arg, write_token, miso_byte, tx_data
//  rsp     | out | exchange, mosi_byte, select, need_tx_data, resp_*, done_res, status
//  csr     | in  | write enable, index, 13-bit data
//
// One beat in, one beat out; every beat is decided combinationally from the phase
// register, so one beat is taken per cycle until the skid fills. The result register
// is one deep with a skid register behind it, so req_ready stays high while one
// result waits. Reset (synchronous) returns to idle with the register reset values.
module sd_spi_command_engine_top import sdspi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   sdspi_stream_if.sink   req,
   sdspi_stream_if.source rsp,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [12:0]   csr_wdata
);

   typedef enum logic [13:0] {
      PH_IDLE    = 14'b00000000000001,
      PH_C_READY = 14'b00000000000010,
      PH_C_FRAME = 14'b00000000000100,
      PH_C_RESP  = 14'b00000000001000,
      PH_C_MORE  = 14'b00000000010000,
      PH_R_READY = 14'b00000000100000,
      PH_R_TOKEN = 14'b00000001000000,
      PH_R_DATA  = 14'b00000010000000,
      PH_R_CRC   = 14'b00000100000000,
      PH_W_READY = 14'b00001000000000,
      PH_W_DATA  = 14'b00010000000000,
      PH_W_CRC   = 14'b00100000000000,
      PH_W_RESP  = 14'b01000000000000,
      PH_W_BUSY  = 14'b10000000000000
   } phase_type;

   logic [12:0] block_bytes_ff;
   logic [7:0]  resp_timeout_ff, ready_tries_ff, token_tries_ff;
   logic [3:0]  max_resp_ff;

   phase_type   phase_ff, phase_in;
   logic [39:0] frame_ff, frame_in;
   logic [6:0]  crc_ff, crc_in;
   logic [7:0]  poll_ff, poll_in;
   logic [11:0] bcnt_ff, bcnt_in;
   logic [3:0]  rcnt_ff, rcnt_in;
   logic        prefix_ff, prefix_in;
   logic [5:0]  idx_ff, idx_in;
   logic [31:0] arg_ff, arg_in;
   logic [7:0]  tok_ff, tok_in;

   rsp_type     r;
   logic        out_v_ff, skid_v_ff;
   rsp_type     out_ff, skid_ff;
   logic        take;

   assign req.ready = !skid_v_ff;
   assign take      = req.valid && req.ready;
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff  <= 13'd512;
         resp_timeout_ff <= 8'd50;
         ready_tries_ff  <= 8'd100;
         token_tries_ff  <= 8'd150;
         max_resp_ff     <= 4'd10;
      end else if (csr_we) begin
         case (csr_index)
            REG_BLOCK_BYTES: block_bytes_ff  <= csr_wdata;
            REG_RESP_TO:     resp_timeout_ff <= csr_wdata[7:0];
            REG_READY_TRIES: ready_tries_ff  <= csr_wdata[7:0];
            REG_TOKEN_TRIES: token_tries_ff  <= csr_wdata[7:0];
            REG_MAX_RESP:    max_resp_ff     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // effective limits: zero acts as one, block length clamps at 4096
   logic [12:0] blen;
   logic [3:0]  rlimit;
   logic [12:0] bnext;
   logic [3:0]  rnext;
   logic        end_cmd, do_take;
   always_comb begin
      if (block_bytes_ff == 13'd0) blen = 13'd1;
      else if (block_bytes_ff > 13'd4096) blen = 13'd4096;
      else blen = block_bytes_ff;
      rlimit = (max_resp_ff == 4'd0) ? 4'd1 : max_resp_ff;
   end

   always_comb begin
      logic [7:0] b;
      logic       fin;
      logic [2:0] fst;
      logic       restart;
      b = req.data.miso_byte;
      phase_in = phase_ff; frame_in = frame_ff; crc_in = crc_ff; poll_in = poll_ff;
      bcnt_in = bcnt_ff; rcnt_in = rcnt_ff; prefix_in = prefix_ff;
      idx_in = idx_ff; arg_in = arg_ff; tok_in = tok_ff;
      r = '0;
      fin = 1'b0; fst = ST_OK; restart = 1'b0;
      end_cmd = 1'b0; do_take = 1'b0;
      bnext = {1'b0, bcnt_ff} + 13'd1;
      rnext = rcnt_ff + 4'd1;

      if (phase_ff == PH_IDLE) begin
         case (req.data.func)
            FUNC_CMD: begin
               idx_in = req.data.cmd_index; prefix_in = req.data.app_cmd;
               arg_in = req.data.cmd_arg; restart = 1'b1;
            end
            FUNC_READ: begin
               poll_in = 8'd1; phase_in = PH_R_READY;
               r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
            end
            FUNC_WRITE: begin
               tok_in = req.data.write_token; poll_in = 8'd1; phase_in = PH_W_READY;
               r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
            end
            default: ;
         endcase
      end else if (req.data.func == FUNC_BYTE) begin
         case (phase_ff)
            PH_C_READY, PH_R_READY, PH_W_READY: begin
               if (b == BYTE_IDLE) begin
                  r.exchange = 1'b1;
                  if (phase_ff == PH_C_READY) begin
                     bcnt_in = '0; phase_in = PH_C_FRAME; r.mosi_byte = BYTE_IDLE;
                  end else if (phase_ff == PH_R_READY) begin
                     poll_in = 8'd1; phase_in = PH_R_TOKEN; r.mosi_byte = BYTE_IDLE;
                  end else begin
                     bcnt_in = '0; phase_in = PH_W_DATA;
                     r.mosi_byte = tok_ff; r.need_tx_data = 1'b1;
                  end
               end else if (poll_ff >= ready_tries_ff) begin
                  fin = 1'b1;
                  fst = (phase_ff == PH_C_READY && prefix_ff) ? ST_PREFIX : ST_NOT_RDY;
               end else begin
                  poll_in = poll_ff + 8'd1;
                  r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
               end
            end
            PH_C_FRAME: begin
               r.exchange = 1'b1;
               if (bcnt_ff < 12'd5) begin
                  crc_in = crc7_byte(crc_ff, frame_ff[39:32]);
                  frame_in = {frame_ff[31:0], 8'd0};
                  bcnt_in = bnext[11:0];
                  r.mosi_byte = frame_ff[39:32];
               end else if (bcnt_ff == 12'd5) begin
                  bcnt_in = 12'd6;
                  r.mosi_byte = {crc_ff, 1'b1};
               end else begin
                  poll_in = 8'd1; rcnt_in = '0; phase_in = PH_C_RESP;
                  r.mosi_byte = BYTE_IDLE;
               end
            end
            PH_C_RESP: begin
               if (b != BYTE_IDLE) do_take = 1'b1;
               else if (poll_ff >= resp_timeout_ff) begin
                  fin = 1'b1; fst = prefix_ff ? ST_PREFIX : ST_RESP_TO;
               end else begin
                  poll_in = poll_ff + 8'd1;
                  r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
               end
            end
            PH_C_MORE: begin
               if (b == BYTE_IDLE) end_cmd = 1'b1;
               else do_take = 1'b1;
            end
            PH_R_TOKEN: begin
               if (b == BYTE_IDLE) begin
                  if (poll_ff >= token_tries_ff) begin
                     fin = 1'b1; fst = ST_NO_TOKEN;
                  end else begin
                     poll_in = poll_ff + 8'd1;
                     r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
                  end
               end else if (b == TOKEN_READ) begin
                  bcnt_in = '0; phase_in = PH_R_DATA;
                  r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
               end else begin
                  fin = 1'b1; fst = ST_BAD_TOK;
               end
            end
            PH_R_DATA: begin
               r.resp_valid = 1'b1; r.resp_byte = b; r.resp_index = bcnt_ff;
               if (bnext >= blen) begin
                  bcnt_in = 12'd1; phase_in = PH_R_CRC;
               end else bcnt_in = bnext[11:0];
               r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
            end
            PH_R_CRC: begin
               if (bcnt_ff < 12'd2) begin
                  bcnt_in = bnext[11:0];
                  r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
               end else fin = 1'b1;
            end
            PH_W_DATA: begin
               r.exchange = 1'b1; r.mosi_byte = req.data.tx_data;
               if (bnext >= blen) begin
                  bcnt_in = '0; phase_in = PH_W_CRC;
               end else begin
                  bcnt_in = bnext[11:0]; r.need_tx_data = 1'b1;
               end
            end
            PH_W_CRC: begin
               if (bcnt_ff < 12'd2) bcnt_in = bnext[11:0];
               else begin
                  poll_in = 8'd1; phase_in = PH_W_RESP;
               end
               r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
            end
            PH_W_RESP: begin
               if (b == BYTE_IDLE && poll_ff < resp_timeout_ff) begin
                  poll_in = poll_ff + 8'd1;
                  r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
               end else if (b[4:0] == 5'h05) begin
                  phase_in = PH_W_BUSY;
                  r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
               end else begin
                  fin = 1'b1; fst = ST_WR_REJ;
               end
            end
            PH_W_BUSY: begin
               if (b == 8'd0) begin
                  r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
               end else fin = 1'b1;
            end
            default: fin = 1'b1;
         endcase
      end

      // response byte capture; the prefix's first byte marks rejection in crc
      if (do_take) begin
         if (prefix_ff) begin
            if (rcnt_ff == 4'd0) crc_in = {6'd0, (b > 8'd1)};
         end else begin
            r.resp_valid = 1'b1; r.resp_byte = b; r.resp_index = {8'd0, rcnt_ff};
         end
         rcnt_in = rnext;
         if (rnext >= rlimit) end_cmd = 1'b1;
         else begin
            phase_in = PH_C_MORE; r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
         end
      end
      if (end_cmd) begin
         if (prefix_ff) begin
            prefix_in = 1'b0;
            if (crc_in[0]) begin
               fin = 1'b1; fst = ST_PREFIX;
            end else restart = 1'b1;
         end else fin = 1'b1;
      end
      if (restart) begin
         frame_in = {2'b01, (prefix_in ? APP_CMD_IX : idx_in), (prefix_in ? 32'd0 : arg_in)};
         crc_in = '0; bcnt_in = '0; rcnt_in = '0; poll_in = 8'd1;
         phase_in = PH_C_READY;
         r.exchange = 1'b1; r.mosi_byte = BYTE_IDLE;
      end
      if (fin) begin
         phase_in = PH_IDLE; prefix_in = 1'b0;
         r.done_res = 1'b1; r.status = fst;
      end
      r.select = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; frame_ff <= '0; crc_ff <= '0; poll_ff <= '0;
         bcnt_ff <= '0; rcnt_ff <= '0; prefix_ff <= 1'b0;
         idx_ff <= '0; arg_ff <= '0; tok_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in; frame_ff <= frame_in; crc_ff <= crc_in; poll_ff <= poll_in;
         bcnt_ff <= bcnt_in; rcnt_ff <= rcnt_in; prefix_ff <= prefix_in;
         idx_ff <= idx_in; arg_ff <= arg_in; tok_ff <= tok_in;
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!out_v_ff || rsp.ready) begin
            out_v_ff <= skid_v_ff || take;
            skid_v_ff <= 1'b0;
         end else if (take) skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp.ready) out_ff <= skid_v_ff ? skid_ff : r;
      else if (take) skid_ff <= r;
   end

endmodule

// ===== rtl/core/sdspi_checker.sv =====
// Checker: port-level properties of the command engine, bound to the top level
module sdspi_checker import sdspi_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   property p_stall_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data);
   endproperty
   a_stall_hold: assert property (p_stall_hold) else $error("rsp beat changed under stall");

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("accepted beat produced no result");

   a_done_desel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.select)
      else $error("finish left card selected");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.exchange |-> rsp_data.mosi_byte == 8'd0 && !rsp_data.need_tx_data)
      else $error("mosi byte without exchange");

   a_ready_reset: assert property (@(posedge clock) $past(reset) |-> req_ready)
      else $error("not ready after reset");
endmodule

bind sd_spi_command_engine_top sdspi_checker u_sdspi_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
